/* src/wnpi_pkg.sv */
// Shared types, constants and register codes of the weighted nearest palette index unit.
package wnpi_pkg;

    // Default sizing of the palette table and the channel lanes.
    localparam int MAX_COLORS_DEF   = 256;
    localparam int MAX_CHANNELS_DEF = 4;

    // Fixed field widths.
    localparam int CHAN_W   = 8;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int WEIGHT_W = 8;
    // The largest distance is 258 * 255 * 255, which fits in 24 bits.
    localparam int DIST_W   = 24;
    localparam int OUT_W    = 8;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int CCNT_W = 9;
    localparam int NCH_W  = 3;

    localparam logic [1:0] REG_COLOR_COUNT   = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_FIRST_WEIGHT  = 2'd2;

    localparam logic [CCNT_W-1:0]   COLOR_COUNT_RST   = 9'd256;
    localparam logic [NCH_W-1:0]    CHANNEL_COUNT_RST = 3'd3;
    localparam logic [WEIGHT_W-1:0] FIRST_WEIGHT_RST  = 8'd1;

    // Kind of an input word.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [CCNT_W-1:0]   color_count;
        logic [NCH_W-1:0]    channel_count;
        logic [WEIGHT_W-1:0] first_weight;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic capture;
        logic issue;
        logic publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic colors_zero;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

/* src/wnpi_regs.sv */
// Configuration registers of the weighted nearest palette index unit behind an APB-style port.
module wnpi_regs
    import wnpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    // The port never stalls.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes; unknown addresses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_count   <= COLOR_COUNT_RST;
            r_cfg.channel_count <= CHANNEL_COUNT_RST;
            r_cfg.first_weight  <= FIRST_WEIGHT_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_COLOR_COUNT:   r_cfg.color_count   <= pwdata[CCNT_W-1:0];
                REG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[NCH_W-1:0];
                REG_FIRST_WEIGHT:  r_cfg.first_weight  <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (paddr[3:2])
            REG_COLOR_COUNT:   prdata = DATA_W'(r_cfg.color_count);
            REG_CHANNEL_COUNT: prdata = DATA_W'(r_cfg.channel_count);
            REG_FIRST_WEIGHT:  prdata = DATA_W'(r_cfg.first_weight);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* src/wnpi_ctrl.sv */
// Controller state machine that sequences loads and palette searches.
module wnpi_ctrl
    import wnpi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_kind,
    input  t_status i_status,
    output logic    o_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_kind == KIND_MAP) begin
                    n_state = i_status.colors_zero ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (i_status.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load    = i_valid && i_kind == KIND_LOAD;
                o_cmd.capture = i_valid && i_kind == KIND_MAP;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
            end
            ST_DRAIN: ;
            ST_DONE: begin
                o_cmd.publish = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

/* src/wnpi_dp.sv */
// Datapath: palette memory, distance pipeline, running minimum and output register.
module wnpi_dp
    import wnpi_pkg::*;
#(
    parameter int MAX_COLORS   = MAX_COLORS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [7:0]        i_entry_index,
    input  logic [CHAN_W-1:0] i_chan_zero,
    input  logic [CHAN_W-1:0] i_chan_one,
    input  logic [CHAN_W-1:0] i_chan_two,
    input  logic [CHAN_W-1:0] i_chan_three,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_nearest_index
);

    localparam int IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int GW = (IW + 1 > 9) ? IW + 1 : 9;
    localparam int WW = CHAN_W * MAX_CHANNELS;

    logic [CHAN_W-1:0] w_chan_in [4];
    logic [WW-1:0]     w_wdata;
    logic [IW-1:0]     w_waddr;
    logic              w_in_range;
    logic [GW-1:0]     w_colors;
    logic [NCH_W-1:0]  w_chans;
    logic [DIST_W-1:0] w_dist;

    logic [WW-1:0]     r_mem [MAX_COLORS];
    logic [CHAN_W-1:0] r_pix [MAX_CHANNELS];
    logic [IW-1:0]     r_cnt;
    logic [WW-1:0]     r_rd;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [IW-1:0]     r_idx1;
    logic [IW-1:0]     r_idx2;
    logic [IW-1:0]     r_idx3;
    logic [SQ_W-1:0]   r_sq [MAX_CHANNELS];
    logic [DIST_W-1:0] r_dist;
    logic              r_have;
    logic [IW-1:0]     r_best;
    logic [DIST_W-1:0] r_best_dist;
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_out;

    assign w_chan_in[0] = i_chan_zero;
    assign w_chan_in[1] = i_chan_one;
    assign w_chan_in[2] = i_chan_two;
    assign w_chan_in[3] = i_chan_three;

    // Effective counts, saturated to the built table and lane sizes.
    always_comb begin
        if (GW'(i_cfg.color_count) > GW'(MAX_COLORS)) begin
            w_colors = GW'(MAX_COLORS);
        end else begin
            w_colors = GW'(i_cfg.color_count);
        end
        if (i_cfg.channel_count > NCH_W'(MAX_CHANNELS)) begin
            w_chans = NCH_W'(MAX_CHANNELS);
        end else begin
            w_chans = i_cfg.channel_count;
        end
    end

    // Load word: only the channels that a search can reach are kept.
    always_comb begin
        for (int n = 0; n < MAX_CHANNELS; n++) begin
            w_wdata[n*CHAN_W +: CHAN_W] = w_chan_in[n];
        end
    end
    assign w_waddr    = IW'(i_entry_index);
    assign w_in_range = GW'(i_entry_index) < GW'(MAX_COLORS);

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_in_range) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.issue) begin
            r_rd <= r_mem[r_cnt];
        end
    end

    // Pixel capture and entry counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int n = 0; n < MAX_CHANNELS; n++) begin
                r_pix[n] <= w_chan_in[n];
            end
        end
        if (i_cmd.capture) begin
            r_cnt <= '0;
        end else if (i_cmd.issue) begin
            r_cnt <= r_cnt + IW'(1);
        end
    end

    // Squared channel differences; channels beyond the count give zero.
    always_ff @(posedge i_clk) begin
        for (int n = 0; n < MAX_CHANNELS; n++) begin
            logic [CHAN_W-1:0] p;
            logic [CHAN_W-1:0] q;
            logic [SQ_W-1:0]   d;
            p = r_pix[n];
            q = r_rd[n*CHAN_W +: CHAN_W];
            d = SQ_W'((p > q) ? p - q : q - p);
            if (NCH_W'(n) < w_chans) begin
                r_sq[n] <= d * d;
            end else begin
                r_sq[n] <= '0;
            end
        end
    end

    // Weighted sum of the channel terms.
    always_comb begin
        w_dist = DIST_W'(r_sq[0]) * DIST_W'(i_cfg.first_weight);
        for (int n = 1; n < MAX_CHANNELS; n++) begin
            w_dist = w_dist + DIST_W'(r_sq[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= w_dist;
        r_idx1 <= r_cnt;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Running minimum; a strict compare keeps the first entry on a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_best <= '0;
        end else if (i_cmd.capture) begin
            r_have <= 1'b0;
            r_best <= '0;
        end else if (r_v3 && (!r_have || r_dist < r_best_dist)) begin
            r_have <= 1'b1;
            r_best <= r_idx3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && (!r_have || r_dist < r_best_dist)) begin
            r_best_dist <= r_dist;
        end
    end

    // Output register holds a finished word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out <= OUT_W'(r_best);
        end
    end

    assign o_valid         = r_ovalid;
    assign o_nearest_index = r_out;

    // Status to the controller.
    assign o_status.colors_zero = (w_colors == '0);
    assign o_status.issue_last  = (GW'(r_cnt) + GW'(1)) == w_colors;
    assign o_status.pipe_busy   = r_v1 || r_v2 || r_v3;
    assign o_status.out_free    = !r_ovalid || i_ready;

endmodule

/* src/weighted_nearest_palette_index_unit.sv */
// Top level of the weighted nearest palette index unit.
// A load word is taken without a stall and gives no result; the next word may follow at once.
// A map word reads one palette entry per cycle from the single memory port; its result is
// offered after the search has drained through the distance pipeline, and the next
// word is accepted when that result is offered, later only while the previous result is not taken.
// Synchronous active-low reset clears control state and restores register defaults only.
module weighted_nearest_palette_index_unit
    import wnpi_pkg::*;
#(
    parameter int MAX_COLORS   = MAX_COLORS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_entry_index,
    input  logic [CHAN_W-1:0] i_chan_zero,
    input  logic [CHAN_W-1:0] i_chan_one,
    input  logic [CHAN_W-1:0] i_chan_two,
    input  logic [CHAN_W-1:0] i_chan_three,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_nearest_index
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    // Configuration registers.
    wnpi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    wnpi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd)
    );

    // Memory and distance datapath.
    wnpi_dp #(
        .MAX_COLORS   (MAX_COLORS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_entry_index   (i_entry_index),
        .i_chan_zero     (i_chan_zero),
        .i_chan_one      (i_chan_one),
        .i_chan_two      (i_chan_two),
        .i_chan_three    (i_chan_three),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_nearest_index (o_nearest_index)
    );

endmodule

/* tb/weighted_nearest_palette_index_unit_tb.sv */
// Self-checking testbench for the weighted nearest palette index unit.
`timescale 1ns / 100ps

module weighted_nearest_palette_index_unit_tb;
    import wnpi_pkg::*;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Cycles that let a map word finish after the last result, with margin.
    localparam int SETTLE_CYCLES  = MAX_COLORS_DEF + 16;
    // Cycles in a row without any accepted word before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 10;
    localparam int ROWS           = 30;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_MAP,
        ROW_REG
    } t_row_op;

    // One line of the directed table. For register rows, index holds the register.
    typedef struct packed {
        t_row_op          op;
        logic [7:0]       index;
        logic [31:0]      data;
        logic             has_exp;
        logic [OUT_W-1:0] exp;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid;
    logic              o_ready;
    logic              i_kind;
    logic [7:0]        i_entry_index;
    logic [CHAN_W-1:0] i_chan_zero;
    logic [CHAN_W-1:0] i_chan_one;
    logic [CHAN_W-1:0] i_chan_two;
    logic [CHAN_W-1:0] i_chan_three;
    logic              o_valid;
    logic              i_ready;
    logic [OUT_W-1:0]  o_nearest_index;

    // Local copy of the block state and configuration.
    logic [31:0]         palette_model [MAX_COLORS_DEF];
    logic [CCNT_W-1:0]   cfg_colors;
    logic [NCH_W-1:0]    cfg_channels;
    logic [WEIGHT_W-1:0] cfg_weight;

    logic [OUT_W-1:0] expected_index_q [$];

    int error_count      = 0;
    int load_count       = 0;
    int map_count        = 0;
    int reg_write_count  = 0;
    int result_count     = 0;
    int idle_cycles      = 0;
    int sender_idle_pct  = 0;
    int ready_stall_pct  = 0;

    weighted_nearest_palette_index_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_chan_zero     (i_chan_zero),
        .i_chan_one      (i_chan_one),
        .i_chan_two      (i_chan_two),
        .i_chan_three    (i_chan_three),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_nearest_index (o_nearest_index)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Weighted squared distance search over the local palette copy.
    function automatic logic [OUT_W-1:0] nearest_entry(input logic [31:0] pixel);
        int unsigned colors;
        int unsigned chans;
        int unsigned distance;
        int unsigned best_dist;
        int unsigned p;
        int unsigned q;
        int unsigned d;
        int unsigned sq;
        int i;
        int n;
        logic [OUT_W-1:0] best;
        colors = (cfg_colors > MAX_COLORS_DEF) ? MAX_COLORS_DEF : cfg_colors;
        chans  = (cfg_channels > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : cfg_channels;
        best = '0;
        best_dist = 0;
        if (colors == 0 || chans == 0) begin
            return '0;
        end
        for (i = 0; i < colors; i++) begin
            distance = 0;
            for (n = 0; n < chans; n++) begin
                p = pixel[n*8 +: 8];
                q = palette_model[i][n*8 +: 8];
                d = (p > q) ? p - q : q - p;
                sq = d * d;
                if (n == 0) begin
                    sq = sq * cfg_weight;
                end
                distance = distance + sq;
            end
            // The lowest index keeps a tie.
            if (i == 0 || distance < best_dist) begin
                best_dist = distance;
                best = OUT_W'(i);
            end
        end
        return best;
    endfunction

    // Number of entries a map word searches, never zero so it can bound a pick.
    function automatic int search_span();
        if (cfg_colors == 0 || cfg_colors > MAX_COLORS_DEF) begin
            return MAX_COLORS_DEF;
        end
        return cfg_colors;
    endfunction

    // Moves every channel of a word a few steps, clamped to the byte range.
    function automatic logic [31:0] jitter(input logic [31:0] base);
        logic [31:0] w;
        int v;
        int n;
        for (n = 0; n < 4; n++) begin
            v = int'(base[n*8 +: 8]) + int'($urandom_range(6)) - 3;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            w[n*8 +: 8] = 8'(v);
        end
        return w;
    endfunction

    // Channel content: uniform, extremes, a narrow range that makes ties, or near an entry.
    function automatic logic [31:0] random_channels();
        logic [31:0] w;
        int n;
        case ($urandom_range(3))
            0: begin
                w = $urandom;
            end
            1: begin
                for (n = 0; n < 4; n++) w[n*8 +: 8] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            end
            2: begin
                for (n = 0; n < 4; n++) w[n*8 +: 8] = 8'($urandom_range(3));
            end
            default: begin
                w = jitter(palette_model[$urandom_range(search_span() - 1)]);
            end
        endcase
        return w;
    endfunction

    function automatic t_row load_row(input logic [7:0] index, input logic [31:0] data);
        return '{op: ROW_LOAD, index: index, data: data, has_exp: 1'b0, exp: '0};
    endfunction

    // An expectation below zero leaves the row to the predictor.
    function automatic t_row map_row(input logic [31:0] data, input int exp);
        return '{op: ROW_MAP, index: 8'd0, data: data, has_exp: (exp >= 0),
                 exp: OUT_W'(exp)};
    endfunction

    function automatic t_row reg_row(input logic [1:0] index, input logic [31:0] value);
        return '{op: ROW_REG, index: {6'd0, index}, data: value, has_exp: 1'b0, exp: '0};
    endfunction

    // Directed table; the palette holds entry i = {i, i, i, i} when it starts.
    t_row directed_rows [ROWS] = '{
        map_row(32'h00000000, 0),
        map_row(32'hFFFFFFFF, 255),
        map_row(32'h004D4D4D, 77),              // fourth channel not compared
        map_row(32'h0A0A0AC8, -1),
        reg_row(REG_CHANNEL_COUNT, 32'd4),
        map_row(32'h80808080, 128),
        reg_row(REG_FIRST_WEIGHT, 32'd0),
        map_row(32'h32323200, 50),              // first channel weighted out
        reg_row(REG_FIRST_WEIGHT, 32'd255),
        map_row(32'hC8C8C80A, -1),
        load_row(8'd10, 32'h28282828),
        map_row(32'h28282828, 10),              // tie with entry 40, lower index wins
        load_row(8'd255, 32'h00000000),
        map_row(32'h00000000, 0),               // tie with entry 255
        load_row(8'd5, 32'h00FF00FF),
        map_row(32'h00FF00FF, 5),
        reg_row(REG_COLOR_COUNT, 32'd1),
        map_row(32'hFFFFFFFF, 0),
        reg_row(REG_COLOR_COUNT, 32'd0),
        map_row(32'h09090909, 0),               // nothing searched
        reg_row(REG_COLOR_COUNT, 32'd511),      // saturates to the table size
        map_row(32'hFEFEFEFE, 254),
        reg_row(REG_CHANNEL_COUNT, 32'd0),
        map_row(32'h64646464, 0),               // no channel compared
        reg_row(REG_CHANNEL_COUNT, 32'd7),      // saturates to four channels
        map_row(32'h03030303, 3),
        reg_row(REG_UNUSED, 32'd0),
        map_row(32'h07070707, 7),
        reg_row(REG_FIRST_WEIGHT, 32'd0),
        map_row(32'h59432D00, -1)
    };

    // Random phase settings; extremes and saturating values among them.
    int phase_colors   [PHASES] = '{16, 256, 1, 37, 0, 511, 8, 64, 2, 100};
    int phase_channels [PHASES] = '{3, 4, 1, 2, 5, 3, 0, 4, 7, 2};
    int phase_weights  [PHASES] = '{1, 255, 0, 128, 3, 17, 200, 1, 255, 0};

    // Receiver side: ready is redrawn every cycle.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Result checker against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            result_count <= result_count + 1;
            if (expected_index_q.size() == 0) begin
                $display("%0t: unexpected nearest_index %0d with no word pending",
                         $time, o_nearest_index);
                error_count <= error_count + 1;
            end else begin
                if (o_nearest_index !== expected_index_q[0]) begin
                    $display("%0t: nearest_index mismatch: expected %0d, actual %0d",
                             $time, expected_index_q[0], o_nearest_index);
                    error_count <= error_count + 1;
                end
                void'(expected_index_q.pop_front());
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("weighted_nearest_palette_index_unit verification failed");
                $finish;
            end
        end
    end

    // Offers one word, waits for its acceptance and records what it should cause.
    task automatic send_word(input logic kind, input logic [7:0] index, input logic [31:0] data,
                             input logic has_exp, input logic [OUT_W-1:0] exp);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= index;
        i_chan_zero   <= data[7:0];
        i_chan_one    <= data[15:8];
        i_chan_two    <= data[23:16];
        i_chan_three  <= data[31:24];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (kind == KIND_LOAD) begin
            palette_model[index] = data;
            load_count++;
        end else begin
            expected_index_q.push_back(has_exp ? exp : nearest_entry(data));
            map_count++;
        end
    endtask

    // Lets the block run dry before a register write or the end of the run.
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (expected_index_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write over the configuration port, followed by a read back of any real register.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        logic [31:0] stored;
        case (index)
            REG_COLOR_COUNT:   cfg_colors   = value[CCNT_W-1:0];
            REG_CHANNEL_COUNT: cfg_channels = value[NCH_W-1:0];
            REG_FIRST_WEIGHT:  cfg_weight   = value[WEIGHT_W-1:0];
            default: ;
        endcase
        case (index)
            REG_COLOR_COUNT:   stored = 32'(cfg_colors);
            REG_CHANNEL_COUNT: stored = 32'(cfg_channels);
            default:           stored = 32'(cfg_weight);
        endcase
        reg_write_count++;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (index != REG_UNUSED) begin
            @(posedge i_clk);
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            if (prdata !== stored) begin
                $display("%0t: register %0d read back mismatch: expected %0d, actual %0d",
                         $time, index, stored, prdata);
                error_count++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        // The port idles before anything else is driven.
        @(posedge i_clk);
    endtask

    // Main stimulus.
    initial begin : stimulus
        int r;
        int p;
        int k;
        int items;
        logic kind;
        logic [7:0] index;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_LOAD;
        i_entry_index <= '0;
        i_chan_zero   <= '0;
        i_chan_one    <= '0;
        i_chan_two    <= '0;
        i_chan_three  <= '0;
        cfg_colors    = COLOR_COUNT_RST;
        cfg_channels  = CHANNEL_COUNT_RST;
        cfg_weight    = FIRST_WEIGHT_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry is written before any map word can search it.
        for (k = 0; k < MAX_COLORS_DEF; k++) begin
            send_word(KIND_LOAD, 8'(k), {4{8'(k)}}, 1'b0, '0);
        end

        // Directed table.
        for (r = 0; r < ROWS; r++) begin
            case (directed_rows[r].op)
                ROW_REG: begin
                    settle_idle();
                    write_register(directed_rows[r].index[1:0], directed_rows[r].data);
                end
                ROW_LOAD: begin
                    send_word(KIND_LOAD, directed_rows[r].index, directed_rows[r].data,
                              1'b0, '0);
                end
                default: begin
                    send_word(KIND_MAP, 8'($urandom), directed_rows[r].data,
                              directed_rows[r].has_exp, directed_rows[r].exp);
                end
            endcase
        end

        // Random phases, each with its own settings and idling pattern.
        for (p = 0; p < PHASES; p++) begin
            settle_idle();
            write_register(REG_COLOR_COUNT, 32'(phase_colors[p]));
            write_register(REG_CHANNEL_COUNT, 32'(phase_channels[p]));
            write_register(REG_FIRST_WEIGHT, 32'(phase_weights[p]));
            case (p % 4)
                0: begin sender_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin sender_idle_pct = 77; ready_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  ready_stall_pct = 77; end
                default: begin sender_idle_pct = 9; ready_stall_pct = 9; end
            endcase
            // Full-size searches are slow, so those phases carry fewer words.
            items = (search_span() > 128) ? 120 : 220;
            for (k = 0; k < items; k++) begin
                kind  = ($urandom_range(99) < 40) ? KIND_LOAD : KIND_MAP;
                index = ($urandom_range(3) != 0) ? 8'($urandom_range(search_span() - 1))
                                                 : 8'($urandom);
                send_word(kind, index, random_channels(), 1'b0, '0);
            end
        end

        sender_idle_pct = 0;
        ready_stall_pct = 0;
        settle_idle();
        $display("Run covered %0d palette loads, %0d pixel maps and %0d register writes.",
                 load_count, map_count, reg_write_count);
        $display("Checked %0d results over %0d random phases; %0d errors seen.",
                 result_count, PHASES, error_count);
        if (error_count == 0) begin
            $display("weighted_nearest_palette_index_unit verification clean");
        end else begin
            $display("weighted_nearest_palette_index_unit verification failed");
        end
        $finish;
    end

endmodule
